// ===== src/swrm_pkg.sv =====
package swrm_pkg;

	localparam int RATE_W = 38;
	localparam logic [63:0] RATE_MAX = (64'd1 << RATE_W) - 64'd1;
	localparam logic [31:0] WINDOW_RESET = 32'd1000;
	localparam int FRAC_W = 16;

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_QUERY = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRUNE_RD,
		ST_PRUNE_CHK,
		ST_EVICT_RD,
		ST_EVICT,
		ST_APPEND,
		ST_SPAN_OLD,
		ST_SPAN_NEW,
		ST_SPAN_CHK,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] time_ticks;
		logic [15:0] units_done;
	} in_item_t;

	typedef struct packed {
		logic              rate_valid;
		logic [RATE_W-1:0] rate_value;
		logic [6:0]        sample_count;
		logic              overflow_dropped;
	} out_item_t;

	typedef struct packed {
		logic cap;
		logic clear;
		logic rd_en;
		logic rd_newest;
		logic drop;
		logic set_dropped;
		logic write_new;
		logic latch_old;
		logic div_start;
		logic load_out;
		logic res_valid;
	} dp_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic count_full;
		logic count_lt2;
		logic expired;
		logic span_pos;
	} dp_stat_t;

endpackage

// ===== src/swrm_div.sv =====
module swrm_div #(
	parameter int DVD_W = 38
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [31:0]      divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] acc_q;
	logic [31:0]      rem_q;
	logic [31:0]      div_q;
	logic [32:0]      rem_sh;
	logic             ge;
	logic [32:0]      rem_diff;

	assign rem_sh   = {rem_q, acc_q[DVD_W-1]};
	assign ge       = rem_sh >= {1'b0, div_q};
	assign rem_diff = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[DVD_W-2:0], ge};
			rem_q <= ge ? rem_diff[31:0] : rem_sh[31:0];
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;
endmodule

// ===== src/swrm_dp.sv =====
module swrm_dp #(
	parameter int SAMPLE_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swrm_pkg::in_item_t   in_data,
	input  logic                 cfg_wr,
	input  logic [31:0]          cfg_data,
	input  swrm_pkg::dp_cmd_t    cmd,
	output swrm_pkg::dp_stat_t   stat,
	output logic [15+$clog2(SAMPLE_DEPTH)+swrm_pkg::FRAC_W:0] dividend,
	output logic [31:0]          divisor,
	input  logic [15+$clog2(SAMPLE_DEPTH)+swrm_pkg::FRAC_W:0] quotient,
	output swrm_pkg::out_item_t  out_data
);
	import swrm_pkg::*;

	localparam int IDX_W = $clog2(SAMPLE_DEPTH);
	localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1);
	localparam int TOT_W = 16 + IDX_W;
	localparam int SUM_W = IDX_W + 1;

	logic [31:0]      time_mem [SAMPLE_DEPTH];
	logic [15:0]      unit_mem [SAMPLE_DEPTH];

	logic [31:0]      window_q;
	logic [31:0]      now_q;
	logic [15:0]      units_q;
	logic             dropped_q;
	logic [IDX_W-1:0] oldest_q;
	logic [CNT_W-1:0] count_q;
	logic [TOT_W-1:0] total_q;
	logic [31:0]      rd_time_q;
	logic [15:0]      rd_unit_q;
	logic [31:0]      old_time_q;
	out_item_t        out_q;

	logic [SUM_W-1:0] slot_sum;
	logic [SUM_W-1:0] newest_sum;
	logic [IDX_W-1:0] slot_idx;
	logic [IDX_W-1:0] newest_idx;
	logic [IDX_W-1:0] oldest_next;
	logic [IDX_W-1:0] rd_addr;
	logic [31:0]      age;
	logic             sat;
	logic [RATE_W-1:0] rate;

	assign slot_sum   = SUM_W'(oldest_q) + SUM_W'(count_q);
	assign newest_sum = SUM_W'(oldest_q) + SUM_W'(count_q) - SUM_W'(1);
	assign slot_idx   = (slot_sum >= SUM_W'(SAMPLE_DEPTH)) ?
		IDX_W'(slot_sum - SUM_W'(SAMPLE_DEPTH)) : IDX_W'(slot_sum);
	assign newest_idx = (newest_sum >= SUM_W'(SAMPLE_DEPTH)) ?
		IDX_W'(newest_sum - SUM_W'(SAMPLE_DEPTH)) : IDX_W'(newest_sum);
	assign oldest_next = (oldest_q == IDX_W'(SAMPLE_DEPTH - 1)) ? '0 : oldest_q + IDX_W'(1);
	assign rd_addr     = cmd.rd_newest ? newest_idx : oldest_q;

	assign age = now_q - rd_time_q;

	assign stat.count_zero = count_q == '0;
	assign stat.count_full = count_q == CNT_W'(SAMPLE_DEPTH);
	assign stat.count_lt2  = count_q < CNT_W'(2);
	assign stat.expired    = (now_q > rd_time_q) && (age > window_q);
	assign stat.span_pos   = rd_time_q > old_time_q;

	assign dividend = {total_q, FRAC_W'(0)};
	assign divisor  = rd_time_q - old_time_q;

	assign sat  = 64'(quotient) > RATE_MAX;
	assign rate = sat ? RATE_W'(RATE_MAX) : RATE_W'(quotient);

	// sample ring
	always_ff @(posedge clk) begin
		if (cmd.write_new) begin
			time_mem[slot_idx] <= now_q;
			unit_mem[slot_idx] <= units_q;
		end
		if (cmd.rd_en) begin
			rd_time_q <= time_mem[rd_addr];
			rd_unit_q <= unit_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= WINDOW_RESET;
			oldest_q  <= '0;
			count_q   <= '0;
			total_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				window_q <= cfg_data;
			end
			if (cmd.cap) begin
				dropped_q <= 1'b0;
			end else if (cmd.set_dropped) begin
				dropped_q <= 1'b1;
			end
			if (cmd.clear) begin
				oldest_q <= '0;
				count_q  <= '0;
				total_q  <= '0;
			end else if (cmd.drop) begin
				oldest_q <= oldest_next;
				count_q  <= count_q - CNT_W'(1);
				total_q  <= total_q - TOT_W'(rd_unit_q);
			end else if (cmd.write_new) begin
				count_q <= count_q + CNT_W'(1);
				total_q <= total_q + TOT_W'(units_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			now_q   <= in_data.time_ticks;
			units_q <= in_data.units_done;
		end
		if (cmd.latch_old) begin
			old_time_q <= rd_time_q;
		end
		if (cmd.load_out) begin
			out_q.rate_valid       <= cmd.res_valid;
			out_q.rate_value       <= cmd.res_valid ? rate : '0;
			out_q.sample_count     <= 7'(count_q);
			out_q.overflow_dropped <= dropped_q;
		end
	end

	assign out_data = out_q;
endmodule

// ===== src/swrm_ctrl.sv =====
module swrm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  swrm_pkg::kind_t    in_kind,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  swrm_pkg::dp_stat_t stat,
	input  logic               div_done,
	output swrm_pkg::dp_cmd_t  cmd
);
	import swrm_pkg::*;

	state_t state_q;
	state_t state_d;
	kind_t  kind_q;
	logic   pass2_q;
	logic   valid_q;
	logic   out_valid_q;
	state_t report_st;

	assign report_st = stat.count_lt2 ? ST_FINISH : ST_SPAN_OLD;

	always_comb begin
		state_d = state_q;
		unique case (state_q) inside
			ST_IDLE: begin
				if (in_valid) begin
					unique case (in_kind) inside
						KIND_ADD, KIND_QUERY: state_d = ST_PRUNE_RD;
						KIND_CLEAR:           state_d = ST_FINISH;
						default:              state_d = report_st;
					endcase
				end
			end
			ST_PRUNE_RD, ST_PRUNE_CHK: begin
				if (state_q == ST_PRUNE_RD && !stat.count_zero) begin
					state_d = ST_PRUNE_CHK;
				end else if (state_q == ST_PRUNE_CHK && stat.expired) begin
					state_d = ST_PRUNE_RD;
				end else if (kind_q == KIND_ADD && !pass2_q) begin
					state_d = stat.count_full ? ST_EVICT_RD : ST_APPEND;
				end else begin
					state_d = report_st;
				end
			end
			ST_EVICT_RD: state_d = ST_EVICT;
			ST_EVICT:    state_d = ST_APPEND;
			ST_APPEND:   state_d = ST_PRUNE_RD;
			ST_SPAN_OLD: state_d = ST_SPAN_NEW;
			ST_SPAN_NEW: state_d = ST_SPAN_CHK;
			ST_SPAN_CHK: state_d = stat.span_pos ? ST_DIV : ST_FINISH;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.cap   = in_valid;
				cmd.clear = in_valid && in_kind == KIND_CLEAR;
			end
			ST_PRUNE_RD:  cmd.rd_en = !stat.count_zero;
			ST_PRUNE_CHK: cmd.drop = stat.expired;
			ST_EVICT_RD:  cmd.rd_en = 1'b1;
			ST_EVICT: begin
				cmd.drop        = 1'b1;
				cmd.set_dropped = 1'b1;
			end
			ST_APPEND:   cmd.write_new = 1'b1;
			ST_SPAN_OLD: cmd.rd_en = 1'b1;
			ST_SPAN_NEW: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_newest = 1'b1;
				cmd.latch_old = 1'b1;
			end
			ST_SPAN_CHK: cmd.div_start = stat.span_pos;
			ST_FINISH: begin
				cmd.load_out  = !out_valid_q || out_ready;
				cmd.res_valid = valid_q;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= KIND_NONE;
			pass2_q     <= 1'b0;
			valid_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_valid) begin
				kind_q  <= in_kind;
				pass2_q <= 1'b0;
			end else if (state_q == ST_APPEND) begin
				pass2_q <= 1'b1;
			end
			if (state_q != ST_FINISH) begin
				valid_q <= state_q == ST_DIV;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
endmodule

// ===== src/sliding_window_rate_meter.sv =====
// channel  dir  handshake                  payload
// in       in   in_valid / in_ready        in_data  (kind, time_ticks, units_done)
// out      out  out_valid / out_ready      out_data (rate fields, count, overflow)
// cfg      in   cfg_valid / cfg_ready      cfg_data (window length)
//
// one request at a time: pruning reads, then checks each sample it looks at (just
// the read on an empty ring); an add appends (evicting the oldest when the ring is
// full) and prunes again; with two or more samples a report reads the oldest and
// newest samples, and a positive span is divided; then the result is handed off
// clear and kind three skip pruning; reset clears the ring and sets the window to 1000
// a finished result waits in the output register while the next request runs
module sliding_window_rate_meter #(
	parameter int SAMPLE_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  swrm_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output swrm_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [31:0]         cfg_data
);
	import swrm_pkg::*;

	localparam int DVD_W = 16 + $clog2(SAMPLE_DEPTH) + FRAC_W;

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic             div_done;
	logic [DVD_W-1:0] dividend;
	logic [DVD_W-1:0] quotient;
	logic [31:0]      divisor;

	assign cfg_ready = 1'b1;

	swrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_kind  (in_data.kind),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.div_done (div_done),
		.cmd      (cmd)
	);

	swrm_dp #(
		.SAMPLE_DEPTH(SAMPLE_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (in_data),
		.cfg_wr  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.cmd     (cmd),
		.stat    (stat),
		.dividend(dividend),
		.divisor (divisor),
		.quotient(quotient),
		.out_data(out_data)
	);

	swrm_div #(
		.DVD_W(DVD_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(dividend),
		.divisor (divisor),
		.done    (div_done),
		.quotient(quotient)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in progress");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.rate_valid |-> out_data.rate_value == '0)
		else $error("invalid rate carries a nonzero value");

	a_div_span: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> stat.span_pos && !stat.count_lt2)
		else $error("division started without a positive span");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !out_valid || out_ready)
		else $error("result register overwritten before it was taken");
endmodule
